// ===== src/glyph_to_page_framebuffer_top_defines.svh =====
// Assertion macros for the glyph frame store block.
// Included by the top level; depends on nothing else.
`ifndef GLYPH_TO_PAGE_FRAMEBUFFER_TOP_DEFINES_SVH
`define GLYPH_TO_PAGE_FRAMEBUFFER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GTP_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GTP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/gtp_pkg.sv =====
// Shared types, command codes and the 5x7 font table of the glyph frame store.
// Used by gtp_step_map and glyph_to_page_framebuffer_top; depends on nothing.
`timescale 1ns / 1ps

package gtp_pkg;

  typedef enum logic [1:0] {
    CMD_DRAW_AT     = 2'd0,
    CMD_DRAW_CURSOR = 2'd1,
    CMD_CLEAR       = 2'd2,
    CMD_READ        = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_DRAW,
    ST_CLEAR,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] mask;
  } step_map_t;

  localparam int GLYPH_W       = 5;
  localparam int GLYPH_H       = 7;
  localparam int GLYPH_ADVANCE = 6;
  localparam int CURSOR_MAX    = 255;
  localparam int DRAW_STEPS    = 2 * GLYPH_H;

  localparam logic [7:0] FIRST_CODE = 8'd32;
  localparam logic [7:0] LAST_CODE  = 8'd126;
  localparam logic [7:0] SUBST_CODE = 8'd63;

  // One entry per printable code; byte n holds glyph column n, bit 0 at the top row.
  localparam logic [39:0] GLYPH_ROM [0:94] = '{
    40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
    40'h122A7F2A24, 40'h6264081323, 40'h5022554936, 40'h0000030500,
    40'h0041221C00, 40'h001C224100, 40'h14083E0814, 40'h08083E0808,
    40'h0000305000, 40'h0808080808, 40'h0000606000, 40'h0204081020,
    40'h3E4549513E, 40'h00407F4200, 40'h4649516142, 40'h314B454121,
    40'h107F121418, 40'h3945454527, 40'h3049494A3C, 40'h0305097101,
    40'h3649494936, 40'h1E29494906, 40'h0000363600, 40'h0000365600,
    40'h0041221408, 40'h1414141414, 40'h0814224100, 40'h0609510102,
    40'h3E41794932, 40'h7E1111117E, 40'h364949497F, 40'h224141413E,
    40'h1C2241417F, 40'h414949497F, 40'h010909097F, 40'h7A4949413E,
    40'h7F0808087F, 40'h00417F4100, 40'h013F414020, 40'h412214087F,
    40'h404040407F, 40'h7F020C027F, 40'h7F1008047F, 40'h3E4141413E,
    40'h060909097F, 40'h5E2151413E, 40'h462919097F, 40'h3149494946,
    40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F,
    40'h6314081463, 40'h0708700807, 40'h4345495161, 40'h0041417F00,
    40'h2010080402, 40'h007F414100, 40'h0402010204, 40'h4040404040,
    40'h0004020100, 40'h7854545420, 40'h384444487F, 40'h2044444438,
    40'h7F48444438, 40'h1854545438, 40'h0201097E08, 40'h3E5252520C,
    40'h780404087F, 40'h00407D4400, 40'h003D444020, 40'h004428107F,
    40'h00407F4100, 40'h780418047C, 40'h780404087C, 40'h3844444438,
    40'h081414147C, 40'h7C18141408, 40'h080404087C, 40'h2054545448,
    40'h2040443F04, 40'h7C2040403C, 40'h1C2040201C, 40'h3C4030403C,
    40'h4428102844, 40'h3C5050500C, 40'h444C546444, 40'h0041360800,
    40'h00007F0000, 40'h0008364100, 40'h0810080810
  };

  function automatic logic [39:0] glyph_lookup(input logic [7:0] code);
    logic [7:0] c;
    c = code;
    if (c < FIRST_CODE || c > LAST_CODE) begin
      c = SUBST_CODE;
    end
    return GLYPH_ROM[7'(c - FIRST_CODE)];
  endfunction

endpackage

// ===== src/gtp_step_map.sv =====
// Maps one step of a glyph draw (glyph row and page half) to a frame byte
// address and an OR mask, with panel clipping. Depends on gtp_pkg.
`timescale 1ns / 1ps

module gtp_step_map
  import gtp_pkg::*;
#(
  parameter int PANEL_COLS = 64,
  parameter int PANEL_ROWS = 128,
  parameter int ADDR_W     = 10
) (
  input  logic signed [8:0] draw_x,
  input  logic signed [8:0] draw_y,
  input  logic [39:0]       glyph,
  input  logic [3:0]        step,
  output step_map_t         map,
  output logic [ADDR_W-1:0] addr
);

  localparam int PAGE_COUNT = (PANEL_ROWS + 7) / 8;
  localparam int ROW_REM    = PANEL_ROWS % 8;
  localparam logic [7:0] LAST_MASK = (ROW_REM == 0) ? 8'hFF : 8'((1 << ROW_REM) - 1);
  localparam int SW = 12;

  logic [2:0]           row;
  logic [GLYPH_W-1:0]   row_bits;
  logic [15:0]          window;
  logic [7:0]           mask;
  logic signed [SW-1:0] ly;
  logic signed [SW-1:0] pc;
  logic signed [SW-1:0] page;
  logic                 col_ok;
  logic                 page_ok;

  always_comb begin
    row = step[3:1];
    for (int c = 0; c < GLYPH_W; c++) begin
      row_bits[c] = glyph[c * 8 + int'(row)];
    end
    window = 16'(row_bits) << draw_x[2:0];

    ly   = SW'(draw_y) + $signed({{(SW - 3){1'b0}}, row});
    pc   = SW'(PANEL_COLS - 1) - ly;
    page = SW'(draw_x >>> 3) + $signed({{(SW - 1){1'b0}}, step[0]});

    col_ok  = (pc >= 0) && (pc < SW'(PANEL_COLS));
    page_ok = (page >= 0) && (page < SW'(PAGE_COUNT));

    mask = step[0] ? window[15:8] : window[7:0];
    if (page == SW'(PAGE_COUNT - 1)) begin
      mask = mask & LAST_MASK;
    end

    map.hit  = col_ok && page_ok && (mask != 8'd0);
    map.mask = mask;
    addr     = ADDR_W'(page) * ADDR_W'(PANEL_COLS) + ADDR_W'(pc);
  end

endmodule

// ===== src/glyph_to_page_framebuffer_top.sv =====
// Top level of the glyph frame store: command sequencer, cursor and frame memory.
// Depends on gtp_pkg, gtp_step_map and glyph_to_page_framebuffer_top_defines.svh.
//
//   channel | direction | handshake              | payload
//   in      | input     | in_valid / in_stall    | cmd, char_code, pos_x, pos_y, byte_address
//   out     | output    | out_valid / out_stall  | read_data
//
// A draw runs through acceptance, 14 read-modify-write steps on the single
// frame memory port pair, and a finish state that retires the last write.
// A read is accepted, reads its byte and then finishes; a clear sweeps the memory one byte a cycle,
// all PANEL_COLS * ceil(PANEL_ROWS / 8) bytes (1024 by default).
// After reset the same sweep runs before the first transaction.
// A stalled result holds in the output register; the next transaction is taken meanwhile.
`timescale 1ns / 1ps
`include "glyph_to_page_framebuffer_top_defines.svh"

module glyph_to_page_framebuffer_top
  import gtp_pkg::*;
#(
  parameter int PANEL_COLS = 64,
  parameter int PANEL_ROWS = 128
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        cmd,
  input  logic [7:0]        char_code,
  input  logic signed [8:0] pos_x,
  input  logic signed [8:0] pos_y,
  input  logic [9:0]        byte_address,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        read_data
);

  localparam int PAGE_COUNT  = (PANEL_ROWS + 7) / 8;
  localparam int STORE_BYTES = PANEL_COLS * PAGE_COUNT;
  localparam int ADDR_W      = $clog2(STORE_BYTES);

  state_t            state;
  state_t            state_next;
  logic [3:0]        step;
  logic [ADDR_W-1:0] clr_cnt;
  logic signed [8:0] cursor_x;
  logic signed [8:0] cursor_y;
  logic signed [8:0] draw_x;
  logic signed [8:0] draw_y;
  logic [39:0]       glyph;
  cmd_t              op_cmd;
  logic              addr_ok;
  logic              wr_pend;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        wr_mask;
  logic [7:0]        rdata;
  logic [7:0]        mem [0:STORE_BYTES-1];

  cmd_t              in_cmd;
  logic              accept;
  logic              out_free;
  logic              clr_last;
  logic              clearing;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic              load_out;
  step_map_t         map;
  logic [ADDR_W-1:0] map_addr;
  logic signed [9:0] adv_sum;
  logic signed [8:0] adv_x;

  gtp_step_map #(
    .PANEL_COLS(PANEL_COLS),
    .PANEL_ROWS(PANEL_ROWS),
    .ADDR_W    (ADDR_W)
  ) u_step_map (
    .draw_x(draw_x),
    .draw_y(draw_y),
    .glyph (glyph),
    .step  (step),
    .map   (map),
    .addr  (map_addr)
  );

  assign in_cmd   = cmd_t'(cmd);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign clr_last = (clr_cnt == ADDR_W'(STORE_BYTES - 1));
  assign adv_sum  = 10'(cursor_x) + 10'sd6;
  assign adv_x    = (adv_sum > 10'(CURSOR_MAX)) ? 9'(CURSOR_MAX) : adv_sum[8:0];

  always_comb begin
    state_next = state;
    case (state)
      ST_INIT: begin
        if (clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          case (in_cmd)
            CMD_DRAW_AT, CMD_DRAW_CURSOR: state_next = ST_DRAW;
            CMD_CLEAR:                    state_next = ST_CLEAR;
            default:                      state_next = ST_FINISH;
          endcase
        end
      end
      ST_DRAW: begin
        if (step == 4'(DRAW_STEPS - 1)) state_next = ST_FINISH;
      end
      ST_CLEAR: begin
        if (clr_last) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_INIT;
    endcase
  end

  always_comb begin
    in_stall = (state != ST_IDLE);
    clearing = (state == ST_INIT) || (state == ST_CLEAR);
    load_out = (state == ST_FINISH) && out_free;
    rd_en    = 1'b0;
    rd_addr  = map_addr;
    case (state)
      ST_IDLE: begin
        rd_en   = accept && (in_cmd == CMD_READ);
        rd_addr = ADDR_W'(byte_address);
      end
      ST_DRAW: begin
        rd_en = map.hit;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_cnt] <= 8'd0;
    end else if (wr_pend) begin
      mem[wr_addr] <= rdata | wr_mask;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      step      <= 4'd0;
      clr_cnt   <= '0;
      cursor_x  <= '0;
      cursor_y  <= '0;
      wr_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      wr_pend <= (state == ST_DRAW) && map.hit;
      if (clearing) begin
        clr_cnt <= clr_last ? '0 : clr_cnt + 1'b1;
      end
      if (state == ST_DRAW) begin
        step <= step + 4'd1;
      end
      if (accept) begin
        step <= 4'd0;
        if (in_cmd == CMD_DRAW_AT) begin
          cursor_x <= pos_x;
          cursor_y <= pos_y;
        end else if (in_cmd == CMD_DRAW_CURSOR) begin
          cursor_x <= adv_x;
        end
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_cmd  <= in_cmd;
      glyph   <= glyph_lookup(char_code);
      addr_ok <= (32'(byte_address) < 32'(STORE_BYTES));
      if (in_cmd == CMD_DRAW_CURSOR) begin
        draw_x <= adv_x;
        draw_y <= cursor_y;
      end else begin
        draw_x <= pos_x;
        draw_y <= pos_y;
      end
    end
    if (state == ST_DRAW) begin
      wr_addr <= map_addr;
      wr_mask <= map.mask;
    end
    if (load_out) begin
      read_data <= (op_cmd == CMD_READ && addr_ok) ? rdata : 8'd0;
    end
  end

  `GTP_ASSERT_IMPLIES(a_clear_no_rmw, clk, rst, (state == ST_INIT || state == ST_CLEAR), !wr_pend, "Read-modify-write pending during clear sweep.")
  `GTP_ASSERT_NEXT(a_accept_busy, clk, rst, accept, in_stall, "Transaction accepted while previous one still in progress.")
  `GTP_ASSERT_IMPLIES(a_step_range, clk, rst, state == ST_DRAW, step < 4'(DRAW_STEPS), "Draw step counter out of range.")
  `GTP_ASSERT_NEXT(a_finish_loads, clk, rst, load_out, out_valid, "Finished transaction did not present a result.")

endmodule
